>>> src/tlct_pkg.sv
// shared constants and types for the two-level cache hit/miss tracker
package tlct_pkg;

  localparam int ADDR_W = 32;

  localparam int L1_SET_BITS = 4;
  localparam int L1_SETS     = 1 << L1_SET_BITS;
  localparam int L1_TAG_W    = ADDR_W - L1_SET_BITS;

  localparam int L2_SET_BITS = 6;
  localparam int L2_SETS     = 1 << L2_SET_BITS;
  localparam int L2_TAG_W    = ADDR_W - L2_SET_BITS;

  localparam int OFFSET_W  = 4;
  localparam int CFG_IDX_W = 8;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(6);

  localparam logic [CFG_IDX_W-1:0] CFG_L1_OFFSET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_L2_OFFSET = CFG_IDX_W'(1);

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_NONE  = 3'd0,
    ST_RHIT  = 3'd1,
    ST_RMISS = 3'd2,
    ST_WHIT  = 3'd3,
    ST_WMISS = 3'd4
  } acc_state_t;

endpackage

>>> src/tlct_if.sv
// request, result and configuration channel interfaces
interface tlct_req_if import tlct_pkg::*;;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [ADDR_W-1:0]   address;

  modport source (output valid, output mode, output address, input ready);
  modport sink   (input valid, input mode, input address, output ready);
endinterface

interface tlct_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] l1_state;
  logic [2:0] l2_state;

  modport source (output valid, output l1_state, output l2_state, input ready);
  modport sink   (input valid, input l1_state, input l2_state, output ready);
endinterface

interface tlct_cfg_if import tlct_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [OFFSET_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/tlct_ram.sv
// generic single-write, single-read ram with registered read data
module tlct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/tlct_level.sv
// one cache level: set row store, lookup, victim choice and fill
module tlct_level import tlct_pkg::*; #(
  parameter int SETS = 16,
  parameter int WAYS = 4,
  parameter int TAGW = 28
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    rd_en,
  input  logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] rd_set,
  input  logic [TAGW-1:0]                         rd_tag,
  input  logic                                    fill_en,
  output logic                                    hit
);

  localparam int SW   = SETS > 1 ? $clog2(SETS) : 1;
  localparam int WW   = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int VLO  = WAYS * TAGW;
  localparam int LLO  = VLO + WAYS;
  localparam int ROWW = LLO + WW;

  logic [SW-1:0]   set_r;
  logic [TAGW-1:0] tag_r;
  logic [SETS-1:0] init_r;
  logic            init_q_r;
  logic            byp_r;
  logic [ROWW-1:0] wrow_r;
  logic [ROWW-1:0] rdata;
  logic [ROWW-1:0] row;
  logic [ROWW-1:0] row_nxt;
  logic [WAYS-1:0] valid;
  logic [WW-1:0]   last;
  logic [WW-1:0]   victim;

  tlct_ram #(.WIDTH(ROWW), .DEPTH(SETS)) u_ram (
    .clk   (clk),
    .we    (fill_en),
    .waddr (set_r),
    .wdata (row_nxt),
    .re    (rd_en),
    .raddr (rd_set),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0;
    end else if (fill_en) begin
      init_r[set_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      set_r    <= rd_set;
      tag_r    <= rd_tag;
      init_q_r <= init_r[rd_set];
      byp_r    <= fill_en && (rd_set == set_r);
    end
    if (fill_en) begin
      wrow_r <= row_nxt;
    end
  end

  // forward a row written in the same cycle it was read
  assign row   = byp_r ? wrow_r : (init_q_r ? rdata : '0);
  assign valid = row[VLO +: WAYS];
  assign last  = row[LLO +: WW];

  always_comb begin
    hit = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (valid[w] && (row[w*TAGW +: TAGW] == tag_r)) begin
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    victim = (last == WW'(WAYS - 1)) ? '0 : last + WW'(1);
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!valid[w]) begin
        victim = WW'(w);
      end
    end
  end

  always_comb begin
    row_nxt = row;
    for (int w = 0; w < WAYS; w++) begin
      if (WW'(w) == victim) begin
        row_nxt[w*TAGW +: TAGW] = tag_r;
        row_nxt[VLO + w]        = 1'b1;
      end
    end
    row_nxt[LLO +: WW] = victim;
  end

endmodule

>>> src/two_level_cache_hit_miss_tracker_core.sv
// two-level cache hit/miss tracker top level
// a result is registered in the lookup stage, then in the output register
// throughput: one request per cycle unless stalled; set rows are read at accept
// and written on a read miss, with forwarding for back-to-back same-set requests
// reset: clears set-initialized flags, round-robin pointers and valid bits read
// as zero; offsets return to 6; tag rams are not cleared
module two_level_cache_hit_miss_tracker_core import tlct_pkg::*; #(
  parameter int L1_WAYS = 4,
  parameter int L2_WAYS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  tlct_req_if.sink   in_req,
  tlct_rsp_if.source out_rsp,
  tlct_cfg_if.sink   cfg_wr
);

  logic [OFFSET_W-1:0]   l1_off_r;
  logic [OFFSET_W-1:0]   l2_off_r;
  logic                  s1_v_r;
  logic                  s1_mode_r;
  logic                  out_v_r;
  acc_state_t            out_l1_r;
  acc_state_t            out_l2_r;
  acc_state_t            l1_st;
  acc_state_t            l2_st;
  logic                  adv;
  logic                  accept;
  logic                  hit1;
  logic                  hit2;
  logic                  fill1;
  logic                  fill2;
  logic [ADDR_W-1:0]     blk1;
  logic [ADDR_W-1:0]     blk2;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_off_r <= OFFSET_RESET;
      l2_off_r <= OFFSET_RESET;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_L1_OFFSET: l1_off_r <= cfg_wr.data;
        CFG_L2_OFFSET: l2_off_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  assign adv          = s1_v_r && (!out_v_r || out_rsp.ready);
  assign in_req.ready = !s1_v_r || adv;
  assign accept       = in_req.valid && in_req.ready;

  assign blk1 = in_req.address >> l1_off_r;
  assign blk2 = in_req.address >> l2_off_r;

  assign fill1 = adv && (s1_mode_r == MODE_READ) && !hit1;
  assign fill2 = fill1 && !hit2;

  tlct_level #(.SETS(L1_SETS), .WAYS(L1_WAYS), .TAGW(L1_TAG_W)) u_l1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_set  (blk1[L1_SET_BITS-1:0]),
    .rd_tag  (blk1[ADDR_W-1:L1_SET_BITS]),
    .fill_en (fill1),
    .hit     (hit1)
  );

  tlct_level #(.SETS(L2_SETS), .WAYS(L2_WAYS), .TAGW(L2_TAG_W)) u_l2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_set  (blk2[L2_SET_BITS-1:0]),
    .rd_tag  (blk2[ADDR_W-1:L2_SET_BITS]),
    .fill_en (fill2),
    .hit     (hit2)
  );

  always_comb begin
    if (s1_mode_r == MODE_WRITE) begin
      l1_st = hit1 ? ST_WHIT : ST_WMISS;
      l2_st = hit2 ? ST_WHIT : ST_WMISS;
    end else begin
      l1_st = hit1 ? ST_RHIT : ST_RMISS;
      l2_st = hit2 ? ST_RHIT : ST_RMISS;
    end
    if (hit1) begin
      l2_st = ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r <= in_req.mode;
    end
    if (adv) begin
      out_l1_r <= l1_st;
      out_l2_r <= l2_st;
    end
  end

  assign out_rsp.valid    = out_v_r;
  assign out_rsp.l1_state = out_l1_r;
  assign out_rsp.l2_state = out_l2_r;

endmodule

>>> src/tlct_checker.sv
// port-level checker for the tracker and its bind
module tlct_checker import tlct_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] l1_state,
  input logic [2:0] l2_state
);

  // result valid holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // an l1 hit never looks at l2
  a_l1_hit_l2_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (l1_state == ST_RHIT || l1_state == ST_WHIT) |-> l2_state == ST_NONE)
    else $error("l2 acted on an l1 hit");

  // an l1 read miss gives a read outcome at l2
  a_read_miss_l2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && l1_state == ST_RMISS |-> (l2_state == ST_RHIT || l2_state == ST_RMISS))
    else $error("l1 read miss without l2 read outcome");

  // an l1 write miss gives a write outcome at l2
  a_write_miss_l2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && l1_state == ST_WMISS |-> (l2_state == ST_WHIT || l2_state == ST_WMISS))
    else $error("l1 write miss without l2 write outcome");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind two_level_cache_hit_miss_tracker_core tlct_checker u_tlct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .l1_state  (out_rsp.l1_state),
  .l2_state  (out_rsp.l2_state)
);
